### hdl/bde_pkg.sv
// bde_pkg: shared types, constants and helpers of the bounded deque engine
// used by bde_ctrl, bde_datapath and bounded_deque_engine_core
// no dependencies
package bde_pkg;

   localparam int DEPTH   = 64;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int COUNT_W = $clog2(DEPTH + 1);
   localparam int VALUE_W = 32;

   typedef enum logic [1:0] {
      OP_PUSH      = 2'd0,
      OP_POP_FRONT = 2'd1,
      OP_POP_BACK  = 2'd2,
      OP_DUMP      = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE  = 2'd0,
      S_FETCH = 2'd1,
      S_SEND  = 2'd2
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       push_wr;
      logic       pop_front;
      logic       pop_back;
      logic       rd_tail;
      logic       ofs_clr;
      logic       ofs_inc;
      logic       ld_imm;
      status_type imm_status;
      logic       ld_mem;
      logic       mem_last;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic empty;
      logic full;
      logic dump_last;
      logic out_last;
   } stat_type;

   // ring position of head plus offset, offset below DEPTH
   function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] base,
                                                  input logic [ADDR_W-1:0] ofs);
      logic [ADDR_W:0] sum;
      sum = {1'b0, base} + {1'b0, ofs};
      if (sum >= (ADDR_W+1)'(DEPTH)) begin
         sum = sum - (ADDR_W+1)'(DEPTH);
      end
      return sum[ADDR_W-1:0];
   endfunction

endpackage

### hdl/bounded_deque_engine_core.sv
// bounded_deque_engine_core: top level of the bounded deque engine
// depends on bde_pkg, bde_ctrl and bde_datapath
//
// A double-ended queue of signed 32-bit values held in a ring buffer of
// bde_pkg::DEPTH entries (64). Each request beat carries an operation: push
// at the tail, pop from the front, pop from the back, or dump every entry from
// head to tail. Push and pop give one response beat each; a dump gives one
// beat per stored entry with last_of_run set on the tail entry. Popping or
// dumping an empty store gives a single beat with status empty, and a push
// into a full store is dropped and answered with status full. One request is
// worked on at a time. A push, or any request answered without a memory read,
// goes from idle straight to the response state; a pop passes through the
// fetch state first, since the entry memory has a registered read port; a
// dump passes through the fetch and response states once per entry. Each
// response is held until rsp_ready. No clearing pass is needed after reset:
// only entries written by a push are ever returned.

module bounded_deque_engine_core (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_op,
   input  logic signed [bde_pkg::VALUE_W-1:0] req_push_value,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [bde_pkg::VALUE_W-1:0] rsp_out_value,
   output logic [1:0]                         rsp_status,
   output logic                               rsp_last_of_run
);

   bde_pkg::cmd_type  cmd;
   bde_pkg::stat_type stat;

   // state machine: idle, memory fetch, response hold
   bde_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // ring memory, pointers and the response register
   bde_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_push_value  (req_push_value),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_out_value   (rsp_out_value),
      .rsp_status      (rsp_status),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

### hdl/bde_ctrl.sv
// bde_ctrl: sequencing state machine of the bounded deque engine
// depends on bde_pkg
module bde_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_op,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  bde_pkg::stat_type stat,
   output bde_pkg::cmd_type  cmd
);

   bde_pkg::state_type state_ff, state_in;
   bde_pkg::op_type    op_ff, op_in;
   bde_pkg::op_type    req_op_e;

   assign req_op_e = bde_pkg::op_type'(req_op);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bde_pkg::S_IDLE;
         op_ff    <= bde_pkg::OP_PUSH;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      case (state_ff)
         bde_pkg::S_IDLE: begin
            if (req_valid) begin
               op_in = req_op_e;
               if (req_op_e == bde_pkg::OP_PUSH || stat.empty) begin
                  state_in = bde_pkg::S_SEND;
               end else begin
                  state_in = bde_pkg::S_FETCH;
               end
            end
         end
         bde_pkg::S_FETCH: begin
            state_in = bde_pkg::S_SEND;
         end
         bde_pkg::S_SEND: begin
            if (rsp_ready) begin
               if (op_ff == bde_pkg::OP_DUMP && !stat.out_last) begin
                  state_in = bde_pkg::S_FETCH;
               end else begin
                  state_in = bde_pkg::S_IDLE;
               end
            end
         end
         default: begin
            state_in = bde_pkg::S_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready      = 1'b0;
      rsp_valid      = 1'b0;
      cmd            = '0;
      cmd.imm_status = bde_pkg::ST_OK;
      case (state_ff)
         bde_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_op_e)
                  bde_pkg::OP_PUSH: begin
                     cmd.ld_imm = 1'b1;
                     if (stat.full) begin
                        cmd.imm_status = bde_pkg::ST_FULL;
                     end else begin
                        cmd.push_wr = 1'b1;
                     end
                  end
                  bde_pkg::OP_POP_FRONT: begin
                     cmd.pop_front = !stat.empty;
                  end
                  bde_pkg::OP_POP_BACK: begin
                     cmd.pop_back = !stat.empty;
                     cmd.rd_tail  = 1'b1;
                  end
                  default: begin
                  end
               endcase
               if (req_op_e != bde_pkg::OP_PUSH && stat.empty) begin
                  cmd.ld_imm     = 1'b1;
                  cmd.imm_status = bde_pkg::ST_EMPTY;
               end
            end
         end
         bde_pkg::S_FETCH: begin
            cmd.ld_mem   = 1'b1;
            cmd.mem_last = (op_ff != bde_pkg::OP_DUMP) || stat.dump_last;
         end
         bde_pkg::S_SEND: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (op_ff == bde_pkg::OP_DUMP && !stat.out_last) begin
                  cmd.ofs_inc = 1'b1;
               end else begin
                  cmd.ofs_clr = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

endmodule

### hdl/bde_datapath.sv
// bde_datapath: entry memory, head and count registers, dump offset and result register
// depends on bde_pkg
module bde_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic signed [bde_pkg::VALUE_W-1:0] req_push_value,
   input  bde_pkg::cmd_type                  cmd,
   output bde_pkg::stat_type                 stat,
   output logic signed [bde_pkg::VALUE_W-1:0] rsp_out_value,
   output logic [1:0]                        rsp_status,
   output logic                              rsp_last_of_run
);

   logic [bde_pkg::VALUE_W-1:0] mem [bde_pkg::DEPTH];

   logic [bde_pkg::ADDR_W-1:0]  head_ff, head_in;
   logic [bde_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [bde_pkg::ADDR_W-1:0]  offset_ff, offset_in;
   logic [bde_pkg::VALUE_W-1:0] rd_data_ff;
   logic [bde_pkg::VALUE_W-1:0] value_ff, value_in;
   bde_pkg::status_type         status_ff, status_in;
   logic                        last_ff, last_in;

   logic [bde_pkg::ADDR_W-1:0]  wr_addr;
   logic [bde_pkg::ADDR_W-1:0]  rd_addr;
   logic [bde_pkg::ADDR_W-1:0]  count_lo;
   logic [bde_pkg::ADDR_W-1:0]  tail_ofs;

   assign count_lo = count_ff[bde_pkg::ADDR_W-1:0];
   assign tail_ofs = count_lo - bde_pkg::ADDR_W'(1);
   assign wr_addr  = bde_pkg::wrap_add(head_ff, count_lo);
   assign rd_addr  = cmd.rd_tail ? bde_pkg::wrap_add(head_ff, tail_ofs)
                                 : bde_pkg::wrap_add(head_ff, offset_in);

   assign stat.empty     = (count_ff == '0);
   assign stat.full      = (count_ff == bde_pkg::COUNT_W'(bde_pkg::DEPTH));
   assign stat.dump_last = (bde_pkg::COUNT_W'(offset_ff) + bde_pkg::COUNT_W'(1)) == count_ff;
   assign stat.out_last  = last_ff;

   // memory: write on push, registered read every cycle
   always_ff @(posedge clock) begin
      if (cmd.push_wr) begin
         mem[wr_addr] <= req_push_value;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      offset_in = offset_ff;
      if (cmd.push_wr) begin
         count_in = count_ff + bde_pkg::COUNT_W'(1);
      end
      if (cmd.pop_front) begin
         head_in  = bde_pkg::wrap_add(head_ff, bde_pkg::ADDR_W'(1));
         count_in = count_ff - bde_pkg::COUNT_W'(1);
      end
      if (cmd.pop_back) begin
         count_in = count_ff - bde_pkg::COUNT_W'(1);
      end
      if (cmd.ofs_clr) begin
         offset_in = '0;
      end else if (cmd.ofs_inc) begin
         offset_in = offset_ff + bde_pkg::ADDR_W'(1);
      end
   end

   always_comb begin
      value_in  = value_ff;
      status_in = status_ff;
      last_in   = last_ff;
      if (cmd.ld_imm) begin
         value_in  = '0;
         status_in = cmd.imm_status;
         last_in   = 1'b1;
      end else if (cmd.ld_mem) begin
         value_in  = rd_data_ff;
         status_in = bde_pkg::ST_OK;
         last_in   = cmd.mem_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         count_ff  <= '0;
         offset_ff <= '0;
         last_ff   <= 1'b0;
      end else begin
         head_ff   <= head_in;
         count_ff  <= count_in;
         offset_ff <= offset_in;
         last_ff   <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff  <= value_in;
      status_ff <= status_in;
   end

   assign rsp_out_value   = signed'(value_ff);
   assign rsp_status      = status_ff;
   assign rsp_last_of_run = last_ff;

endmodule
